@@ rtl/core/psrq_pkg.sv @@
package psrq_pkg;

    // Width of each coordinate field on the ports.
    localparam int FIELD_BITS = 16;

    // Width of the count and length fields on the ports.
    localparam int LEN_BITS = 7;

    typedef enum logic [2:0]
    {
        ACT_PUSH     = 3'd0,
        ACT_POP      = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_COUNT    = 3'd3,
        ACT_CONTAINS = 3'd4
    } action_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_RSQ,
        ST_RWAIT,
        ST_WALK,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    // Status that comes back from the squaring and compare unit.
    typedef struct packed
    {
        logic valid;
        logic eq;
        logic in_range;
    } unit_flags_t;

endpackage

@@ rtl/core/psrq_ram.sv @@
module psrq_ram #(
    parameter int DEPTH      = 64,
    parameter int ADDR_BITS  = 6,
    parameter int DATA_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/psrq_unit.sv @@
module psrq_unit #(
    parameter int COORD_BITS = 16,
    parameter int TAG_BITS   = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [TAG_BITS-1:0]          in_tag,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    input  logic signed [COORD_BITS-1:0] key_a,
    input  logic signed [COORD_BITS-1:0] key_b,
    input  logic [2*COORD_BITS-1:0]      limit,
    output psrq_pkg::unit_flags_t        flags,
    output logic [TAG_BITS-1:0]          tag,
    output logic [2*COORD_BITS-1:0]      sum
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] abs_a;
    logic [COORD_BITS-1:0] abs_b;
    logic [SQ_BITS-1:0]    sq_a_next;
    logic [SQ_BITS-1:0]    sq_b_next;
    logic [SQ_BITS-1:0]    sum_next;

    logic [SQ_BITS-1:0]    sq_a_reg;
    logic [SQ_BITS-1:0]    sq_b_reg;
    logic                  eq1_reg;
    logic                  v1_reg;
    logic [TAG_BITS-1:0]   tag1_reg;

    logic [SQ_BITS-1:0]    sum_reg;
    logic                  within_reg;
    logic                  eq2_reg;
    logic                  v2_reg;
    logic [TAG_BITS-1:0]   tag2_reg;

    // The magnitude of the most negative value still fits as an unsigned pattern.
    assign abs_a     = a[COORD_BITS-1] ? (~a + 1'b1) : a;
    assign abs_b     = b[COORD_BITS-1] ? (~b + 1'b1) : b;
    assign sq_a_next = abs_a * abs_a;
    assign sq_b_next = abs_b * abs_b;
    assign sum_next  = sq_a_reg + sq_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_a_reg   <= sq_a_next;
        sq_b_reg   <= sq_b_next;
        eq1_reg    <= (a == key_a) && (b == key_b);
        tag1_reg   <= in_tag;
        sum_reg    <= sum_next;
        within_reg <= (sum_next <= limit);
        eq2_reg    <= eq1_reg;
        tag2_reg   <= tag1_reg;
    end

    assign flags.valid    = v2_reg;
    assign flags.eq       = eq2_reg;
    assign flags.in_range = within_reg;
    assign tag            = tag2_reg;
    assign sum            = sum_reg;

endmodule

@@ rtl/core/point_stack_with_radius_query.sv @@
// Bounded store of signed points, newest first, with push, pop, delete of the
// newest matching point, count within a radius and a membership test.
// The input channel (in_valid, in_stall) takes one item at a time: in_stall is
// high from the cycle after an item is accepted until its result has been
// placed in the output register. The output channel (out_valid, out_stall)
// holds one result item; a new item may be accepted while it waits.
// Push, pop and unused actions go straight to the finish state. Contains and
// delete walk the stored points newest first until a match or the last entry,
// and delete then reads each entry above the match and writes it one place
// lower to close the gap. Count within radius first squares the radius in the
// unit and then walks every stored point. Each walk is paced by the single
// read port of the point memory, which gives one entry a cycle to the shared
// squaring and compare unit, whose two stages add their latency at the end of
// each walk.
// A stalled receiver holds the result in the output register; the next item
// then waits in the finish state until the register is free.
// Reset empties the store at once; the memory contents are not cleared.
module point_stack_with_radius_query #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [2:0]                            action,
    input  logic signed [psrq_pkg::FIELD_BITS-1:0] x_coord,
    input  logic signed [psrq_pkg::FIELD_BITS-1:0] y_coord,
    input  logic signed [psrq_pkg::FIELD_BITS-1:0] radius,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  ok,
    output logic [psrq_pkg::LEN_BITS-1:0]         match_count,
    output logic [psrq_pkg::LEN_BITS-1:0]         list_length
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ENT_W  = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int WIDE_W = 2 * psrq_pkg::FIELD_BITS;
    localparam int LEN_W  = psrq_pkg::LEN_BITS;

    psrq_pkg::state_t state_reg, state_next;

    logic [2:0]                   act_reg, act_next;
    logic signed [COORD_BITS-1:0] kx_reg, kx_next;
    logic signed [COORD_BITS-1:0] ky_reg, ky_next;
    logic signed [COORD_BITS-1:0] kr_reg, kr_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [1:0]                   pend_reg, pend_next;
    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic [CNT_W-1:0]             mcnt_reg, mcnt_next;
    logic [SQ_W-1:0]              rr_reg, rr_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]             rd_tag_reg, rd_tag_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_ok_reg, out_ok_next;
    logic [LEN_W-1:0]             out_match_reg, out_match_next;
    logic [LEN_W-1:0]             out_len_reg, out_len_next;

    logic [WIDE_W-1:0] x_wide;
    logic [WIDE_W-1:0] y_wide;
    logic [WIDE_W-1:0] r_wide;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ENT_W-1:0] ram_rdata;

    logic                         u_valid;
    logic signed [COORD_BITS-1:0] u_a;
    logic signed [COORD_BITS-1:0] u_b;
    psrq_pkg::unit_flags_t        u_flags;
    logic [IDX_W-1:0]             u_tag;
    logic [SQ_W-1:0]              u_sum;

    logic is_search;
    logic issue;

    // Coordinates are taken from the low bits of the zero-extended field.
    assign x_wide = {{psrq_pkg::FIELD_BITS{1'b0}}, x_coord};
    assign y_wide = {{psrq_pkg::FIELD_BITS{1'b0}}, y_coord};
    assign r_wide = {{psrq_pkg::FIELD_BITS{1'b0}}, radius};

    assign is_search = (act_reg == psrq_pkg::ACT_DELETE) ||
                       (act_reg == psrq_pkg::ACT_CONTAINS);

    // The radius is squared by feeding it through the unit with a zero partner.
    assign u_valid = (state_reg == psrq_pkg::ST_RSQ) ||
                     ((state_reg == psrq_pkg::ST_WALK) && rd_valid_reg);
    assign u_a     = (state_reg == psrq_pkg::ST_RSQ) ? kr_reg
                                                     : ram_rdata[ENT_W-1:COORD_BITS];
    assign u_b     = (state_reg == psrq_pkg::ST_RSQ) ? '0 : ram_rdata[COORD_BITS-1:0];

    psrq_ram #(
        .DEPTH     (MAX_POINTS),
        .ADDR_BITS (IDX_W),
        .DATA_BITS (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    psrq_unit #(
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (IDX_W)
    ) u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (u_valid),
        .in_tag   (rd_tag_reg),
        .a        (u_a),
        .b        (u_b),
        .key_a    (kx_reg),
        .key_b    (ky_reg),
        .limit    (rr_reg),
        .flags    (u_flags),
        .tag      (u_tag),
        .sum      (u_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psrq_pkg::ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= '0;
            found_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        kx_reg        <= kx_next;
        ky_reg        <= ky_next;
        kr_reg        <= kr_next;
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        slot_reg      <= slot_next;
        mcnt_reg      <= mcnt_next;
        rr_reg        <= rr_next;
        rd_tag_reg    <= rd_tag_next;
        out_ok_reg    <= out_ok_next;
        out_match_reg <= out_match_next;
        out_len_reg   <= out_len_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        kr_next        = kr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        mcnt_next      = mcnt_reg;
        rr_next        = rr_reg;
        rd_valid_next  = 1'b0;
        rd_tag_next    = rd_tag_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_match_next = out_match_reg;
        out_len_next   = out_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = {kx_reg, ky_reg};
        ram_re         = 1'b0;
        issue          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            psrq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    kx_next    = x_wide[COORD_BITS-1:0];
                    ky_next    = y_wide[COORD_BITS-1:0];
                    kr_next    = r_wide[COORD_BITS-1:0];
                    found_next = 1'b0;
                    mcnt_next  = '0;
                    pend_next  = '0;
                    rem_next   = count_reg;
                    unique case (action)
                        psrq_pkg::ACT_COUNT:
                        begin
                            idx_next   = '0;
                            state_next = psrq_pkg::ST_RSQ;
                        end
                        psrq_pkg::ACT_DELETE, psrq_pkg::ACT_CONTAINS:
                        begin
                            // Search runs newest first, so the first hit is the one to take.
                            idx_next   = count_reg - 1'b1;
                            state_next = psrq_pkg::ST_WALK;
                        end
                        default:
                        begin
                            state_next = psrq_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            psrq_pkg::ST_RSQ:
            begin
                state_next = psrq_pkg::ST_RWAIT;
            end

            psrq_pkg::ST_RWAIT:
            begin
                if (u_flags.valid)
                begin
                    rr_next    = u_sum;
                    state_next = psrq_pkg::ST_WALK;
                end
            end

            psrq_pkg::ST_WALK:
            begin
                issue = (rem_reg != '0) && !found_reg;
                if (issue)
                begin
                    ram_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_tag_next   = idx_reg[IDX_W-1:0];
                    rem_next      = rem_reg - 1'b1;
                    if (is_search)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                pend_next = pend_reg + {1'b0, issue} - {1'b0, u_flags.valid};

                if (u_flags.valid)
                begin
                    if ((act_reg == psrq_pkg::ACT_COUNT) && u_flags.in_range)
                    begin
                        mcnt_next = mcnt_reg + 1'b1;
                    end
                    if (is_search && u_flags.eq && !found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = u_tag;
                    end
                end

                if (((rem_reg == '0) || found_reg) && (pend_reg == '0))
                begin
                    if ((act_reg == psrq_pkg::ACT_DELETE) && found_reg &&
                        ((CNT_W'(slot_reg) + 1'b1) < count_reg))
                    begin
                        idx_next   = CNT_W'(slot_reg) + 1'b1;
                        rem_next   = count_reg - CNT_W'(slot_reg) - 1'b1;
                        state_next = psrq_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = psrq_pkg::ST_FINISH;
                    end
                end
            end

            psrq_pkg::ST_SHIFT:
            begin
                // Each entry above the match is read and written one place lower.
                if (rem_reg != '0)
                begin
                    ram_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_tag_next   = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
                if (rd_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_tag_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if ((rem_reg == '0) && !rd_valid_reg)
                begin
                    state_next = psrq_pkg::ST_FINISH;
                end
            end

            psrq_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b0;
                    out_match_next = '0;
                    unique case (act_reg)
                        psrq_pkg::ACT_PUSH:
                        begin
                            if (count_reg < CNT_W'(MAX_POINTS))
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                out_ok_next = 1'b1;
                            end
                        end
                        psrq_pkg::ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next  = count_reg - 1'b1;
                                out_ok_next = 1'b1;
                            end
                        end
                        psrq_pkg::ACT_DELETE:
                        begin
                            if (found_reg)
                            begin
                                count_next  = count_reg - 1'b1;
                                out_ok_next = 1'b1;
                            end
                        end
                        psrq_pkg::ACT_COUNT:
                        begin
                            out_ok_next    = (mcnt_reg != '0);
                            out_match_next = LEN_W'(mcnt_reg);
                        end
                        psrq_pkg::ACT_CONTAINS:
                        begin
                            out_ok_next = found_reg;
                        end
                        default:
                        begin
                            out_ok_next = 1'b0;
                        end
                    endcase
                    out_len_next = LEN_W'(count_next);
                    state_next   = psrq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = psrq_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != psrq_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign match_count = out_match_reg;
    assign list_length = out_len_reg;

endmodule

@@ rtl/core/psrq_chk.sv @@
module psrq_chk #(
    parameter int MAX_POINTS = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [psrq_pkg::LEN_BITS-1:0] match_count,
    input logic [psrq_pkg::LEN_BITS-1:0] list_length
);

    // Only one item is ever in work, so the block is busy right after taking one.
    busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took an item while another was in work");

    held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) &&
        $stable(match_count) && $stable(list_length))
        else $error("stalled result item changed");

    count_sets_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (match_count != '0) |-> ok)
        else $error("nonzero count reported without ok");

    count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (MAX_POINTS < 128) |->
        (match_count <= list_length) && (list_length <= MAX_POINTS))
        else $error("count or length beyond the stored points");

endmodule

bind point_stack_with_radius_query psrq_chk #(.MAX_POINTS(MAX_POINTS)) u_psrq_chk (.*);

@@ tb/point_stack_with_radius_query_tb.sv @@
`timescale 1ns / 1ps

module point_stack_with_radius_query_tb;

    localparam int DEPTH          = 64;
    localparam int N_DIRECTED     = 23;
    localparam int N_PHASES       = 7;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    // Action codes that the block must ignore.
    localparam logic [2:0] ACT_RSVD_A = 3'd5;
    localparam logic [2:0] ACT_RSVD_B = 3'd6;
    localparam logic [2:0] ACT_RSVD_C = 3'd7;

    // Phase kinds of the random part.
    localparam int KIND_FILL  = 0;
    localparam int KIND_MIXED = 1;
    localparam int KIND_DRAIN = 2;
    localparam int KIND_QUERY = 3;

    typedef logic signed [psrq_pkg::FIELD_BITS-1:0] coord_t;

    typedef struct packed
    {
        logic                          ok;
        logic [psrq_pkg::LEN_BITS-1:0] cnt;
        logic [psrq_pkg::LEN_BITS-1:0] len;
    } pt_result_t;

    typedef struct packed
    {
        logic [2:0] act;
        coord_t     x;
        coord_t     y;
        coord_t     r;
        logic       typed;
        pt_result_t want;
    } dir_row_t;

    // Cumulative percentages for push, pop, delete, count and contains; the rest is
    // reserved codes.
    localparam int ACT_CUT [4][5] = '{
        '{82, 86, 90, 94, 97},
        '{35, 50, 65, 80, 95},
        '{10, 50, 80, 88, 96},
        '{15, 20, 30, 65, 95}
    };

    localparam int PHASE_KIND [N_PHASES] = '{
        KIND_FILL, KIND_MIXED, KIND_FILL, KIND_QUERY, KIND_DRAIN, KIND_MIXED, KIND_FILL
    };

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{psrq_pkg::ACT_POP,      16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{psrq_pkg::ACT_COUNT,    16'sh0000, 16'sh0000, 16'sh7FFF, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{psrq_pkg::ACT_DELETE,   16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{psrq_pkg::ACT_CONTAINS, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{ACT_RSVD_A,             16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{ACT_RSVD_C,             16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, '{1'b0, 7'd0, 7'd0}},
        '{psrq_pkg::ACT_PUSH,     16'sh8000, 16'sh8000, 16'sh0000, 1'b1, '{1'b1, 7'd0, 7'd1}},
        '{psrq_pkg::ACT_PUSH,     16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, '{1'b1, 7'd0, 7'd2}},
        '{psrq_pkg::ACT_PUSH,     16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{1'b1, 7'd0, 7'd3}},
        '{psrq_pkg::ACT_PUSH,     16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1, '{1'b1, 7'd0, 7'd4}},
        '{psrq_pkg::ACT_COUNT,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_COUNT,    16'sh0000, 16'sh0000, 16'sh8000, 1'b0, '0},
        '{psrq_pkg::ACT_COUNT,    16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0, '0},
        '{psrq_pkg::ACT_CONTAINS, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_CONTAINS, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_PUSH,     16'sh8000, 16'sh8000, 16'sh0000, 1'b1, '{1'b1, 7'd0, 7'd5}},
        '{psrq_pkg::ACT_DELETE,   16'sh8000, 16'sh8000, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_CONTAINS, 16'sh8000, 16'sh8000, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_DELETE,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '0},
        '{psrq_pkg::ACT_DELETE,   16'sh0001, 16'sh0002, 16'sh0000, 1'b0, '0},
        '{ACT_RSVD_B,             16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '0},
        '{psrq_pkg::ACT_POP,      16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, '0},
        '{psrq_pkg::ACT_COUNT,    16'sh0000, 16'sh0000, 16'shFFFF, 1'b0, '0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [2:0]                    action;
    coord_t                        x_coord;
    coord_t                        y_coord;
    coord_t                        radius;
    logic                          out_valid;
    logic                          out_stall;
    logic                          ok;
    logic [psrq_pkg::LEN_BITS-1:0] match_count;
    logic [psrq_pkg::LEN_BITS-1:0] list_length;

    coord_t     shadow_x [DEPTH];
    coord_t     shadow_y [DEPTH];
    int         shadow_len = 0;
    pt_result_t pending_results [$];
    pt_result_t rx_want;
    int         errors = 0;
    int         rx_wait = 0;
    int         quiet = 0;
    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;

    always #10 clk = ~clk;

    point_stack_with_radius_query #(
        .MAX_POINTS(DEPTH),
        .COORD_BITS(psrq_pkg::FIELD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .radius(radius),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .match_count(match_count),
        .list_length(list_length)
    );

    // Applies one item to the shadow store and returns the result it should give.
    function automatic pt_result_t apply_point_op(input logic [2:0] act, input coord_t px,
                                                  input coord_t py, input coord_t pr);
        pt_result_t res;
        int         hit;
        longint     lim;
        longint     mag;
        res = '0;
        hit = -1;
        for (int i = shadow_len - 1; i >= 0; i--)
        begin
            if (hit < 0 && shadow_x[i] == px && shadow_y[i] == py)
                hit = i;
        end
        case (act)
            psrq_pkg::ACT_PUSH:
            begin
                if (shadow_len < DEPTH)
                begin
                    shadow_x[shadow_len] = px;
                    shadow_y[shadow_len] = py;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            psrq_pkg::ACT_POP:
            begin
                if (shadow_len > 0)
                begin
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            psrq_pkg::ACT_DELETE:
            begin
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < shadow_len; i++)
                    begin
                        shadow_x[i] = shadow_x[i + 1];
                        shadow_y[i] = shadow_y[i + 1];
                    end
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            psrq_pkg::ACT_COUNT:
            begin
                lim = longint'(pr) * longint'(pr);
                for (int i = 0; i < shadow_len; i++)
                begin
                    mag = longint'(shadow_x[i]) * longint'(shadow_x[i])
                        + longint'(shadow_y[i]) * longint'(shadow_y[i]);
                    if (mag <= lim)
                        res.cnt = res.cnt + 1'b1;
                end
                res.ok = (res.cnt != '0);
            end
            psrq_pkg::ACT_CONTAINS:
                res.ok = (hit >= 0);
            default:
            begin
            end
        endcase
        res.len = psrq_pkg::LEN_BITS'(shadow_len);
        return res;
    endfunction

    // Mostly a small range so that points repeat, sometimes any value or an extreme.
    function automatic coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return coord_t'(int'($urandom_range(0, 6)) - 3);
        else if (sel < 8)
            return coord_t'($urandom);
        else if (sel == 8)
            return 16'sh8000;
        else
            return 16'sh7FFF;
    endfunction

    task automatic offer_item(input logic [2:0] act, input coord_t px, input coord_t py,
                              input coord_t pr, input logic typed, input pt_result_t want);
        int         gap;
        pt_result_t res;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        x_coord  <= px;
        y_coord  <= py;
        radius   <= pr;
        do
            @(posedge clk);
        while (in_stall);
        res = apply_point_op(act, px, py, pr);
        pending_results.push_back(typed ? want : res);
    endtask

    // Receiver: checks each result item and draws its stall for the next one.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result item with no item pending", $time);
            end
            else
            begin
                rx_want = pending_results.pop_front();
                if (ok !== rx_want.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %0d, got %0d", $time, rx_want.ok, ok);
                end
                if (match_count !== rx_want.cnt)
                begin
                    errors++;
                    $display("%0t: match_count expected %0d, got %0d",
                             $time, rx_want.cnt, match_count);
                end
                if (list_length !== rx_want.len)
                begin
                    errors++;
                    $display("%0t: list_length expected %0d, got %0d",
                             $time, rx_want.len, list_length);
                end
            end
            rx_wait = idle_on ? $urandom_range(0, 9) : 0;
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            rx_wait  = HOLD_CYCLES;
        end
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int         kind;
        int         p;
        int         idx;
        logic [2:0] act;
        coord_t     px;
        coord_t     py;
        coord_t     pr;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= psrq_pkg::ACT_PUSH;
        x_coord  <= '0;
        y_coord  <= '0;
        radius   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            offer_item(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].r,
                       dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            kind    = PHASE_KIND[ph];
            idle_on = (kind != KIND_QUERY);
            // Hold the receiver off for a long stretch so that the input backs up.
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = $urandom_range(0, 99);
                if (p < ACT_CUT[kind][0])
                    act = psrq_pkg::ACT_PUSH;
                else if (p < ACT_CUT[kind][1])
                    act = psrq_pkg::ACT_POP;
                else if (p < ACT_CUT[kind][2])
                    act = psrq_pkg::ACT_DELETE;
                else if (p < ACT_CUT[kind][3])
                    act = psrq_pkg::ACT_COUNT;
                else if (p < ACT_CUT[kind][4])
                    act = psrq_pkg::ACT_CONTAINS;
                else
                    act = 3'($urandom_range(ACT_RSVD_A, ACT_RSVD_C));
                px = rand_coord();
                py = rand_coord();
                // Delete and contains mostly look for a point that is stored.
                if ((act == psrq_pkg::ACT_DELETE || act == psrq_pkg::ACT_CONTAINS)
                    && shadow_len > 0 && $urandom_range(0, 2) != 0)
                begin
                    idx = $urandom_range(0, shadow_len - 1);
                    px  = shadow_x[idx];
                    py  = shadow_y[idx];
                end
                pr = ($urandom_range(0, 1) != 0) ? coord_t'($urandom)
                                                 : coord_t'($urandom_range(0, 6));
                if ($urandom_range(0, 3) == 0)
                    pr = -pr;
                offer_item(act, px, py, pr, 1'b0, '0);
            end
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end

        idle_on = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
